/* rtl/core/sfu_pkg.sv */
// Shared types and constants for the steering force unit.
// No dependencies; imported by steering_force_unit.
`default_nettype none
package sfu_pkg;

  localparam int FracBitsDef = 16;
  localparam int CoordW      = 32;
  localparam int SpeedW      = 31;
  localparam int QuotW       = 32;

  typedef enum logic [2:0] {
    OP_SEEK     = 3'd0,
    OP_FLEE     = 3'd1,
    OP_PURSUIT  = 3'd2,
    OP_EVADE    = 3'd3,
    OP_IVEHPT   = 3'd4,
    OP_IVEHICLES = 3'd5,
    OP_IPOINTS  = 3'd6
  } op_t;

  localparam logic [0:0] REG_FLEE_RADIUS = 1'b0;

endpackage
`default_nettype wire

/* rtl/core/steering_force_unit.sv */
// Steering force unit top level: request decode, distance, square root and divide pipeline.
// Depends on sfu_pkg for operation codes and field widths.
//
//   port group   direction  handshake            word
//   request      in         in_valid / in_stall  operation, positions, speeds, headings
//   force        out        out_valid / out_stall force_x, force_y
//   config       in         APB psel/penable     flee_radius at byte address 0
//
// One request enters per cycle unless the output is stalled. RW is the square root width (51
// at 16 fraction bits): one root bit and one quotient bit per stage. Reset clears all stage
// valid bits and loads flee_radius with 10.0.
// A stalled output word freezes the whole pipeline, so in_stall follows out_stall then.
`default_nettype none
module steering_force_unit #(
  parameter int FRAC_BITS = sfu_pkg::FracBitsDef
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  operation,
  input  wire logic [63:0]                 own_pos,
  input  wire logic [sfu_pkg::SpeedW-1:0]  own_max_speed,
  input  wire logic [63:0]                 a_pos,
  input  wire logic [63:0]                 a_dir,
  input  wire logic [sfu_pkg::SpeedW-1:0]  a_speed,
  input  wire logic [63:0]                 b_pos,
  input  wire logic [63:0]                 b_vel,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [31:0]               force_x,
  output logic signed [31:0]               force_y,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import sfu_pkg::*;

  localparam int PW   = 64 - FRAC_BITS;
  localparam int TW   = PW + 1;
  localparam int DW   = TW + 1;
  localparam int MW   = DW;
  localparam int LO   = MW / 2;
  localparam int HI   = MW - LO;
  localparam int SW   = 2 * MW;
  localparam int SQW  = SW + 1;
  localparam int RW   = (SQW + 1) / 2;
  localparam int TW2  = 2 * RW + 1;
  localparam int NW   = MW + SpeedW;
  localparam int CW   = (NW > RW + QuotW) ? NW : RW + QuotW;
  localparam int SPW  = 2 * SpeedW;
  localparam int SUMW = CoordW + 3;

  typedef struct packed {
    logic              kill;
    logic              sgx;
    logic              sgy;
    logic [MW-1:0]     mx;
    logic [MW-1:0]     my;
    logic [SpeedW-1:0] spd;
  } car_t;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Configuration register
  logic [SpeedW-1:0] flee_radius;
  assign pready = 1'b1;
  assign prdata = {1'b0, flee_radius};
  always_ff @(posedge clk) begin
    if (rst) begin
      flee_radius <= SpeedW'(10) << FRAC_BITS;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FLEE_RADIUS)) begin
      flee_radius <= pwdata[SpeedW-1:0];
    end
  end

  // Stage 1: decode, predicted offsets and midpoint sums
  logic signed [CoordW-1:0] ax, ay, hx, hy, bx, by, vx, vy;
  logic signed [CoordW:0]   aspd_s;
  assign ax = signed'(a_pos[63:32]);
  assign ay = signed'(a_pos[31:0]);
  assign hx = signed'(a_dir[63:32]);
  assign hy = signed'(a_dir[31:0]);
  assign bx = signed'(b_pos[63:32]);
  assign by = signed'(b_pos[31:0]);
  assign vx = signed'(b_vel[63:32]);
  assign vy = signed'(b_vel[31:0]);
  assign aspd_s = signed'({2'b00, a_speed});

  logic                    s1_v, s1_kill, s1_flee;
  logic [2:0]              s1_op;
  logic signed [63:0]      s1_px, s1_py;
  logic signed [SUMW-1:0]  s1_sx, s1_sy;
  logic signed [CoordW-1:0] s1_ax, s1_ay, s1_ox, s1_oy;
  logic [SpeedW-1:0]       s1_spd;
  logic                    kill_d, flee_d;
  logic signed [SUMW-1:0]  sx_d, sy_d;

  always_comb begin
    kill_d = 1'b0;
    flee_d = 1'b0;
    sx_d   = SUMW'(ax) + SUMW'(bx);
    sy_d   = SUMW'(ay) + SUMW'(by);
    case (op_t'(operation))
      OP_SEEK, OP_PURSUIT, OP_IPOINTS: ;
      OP_FLEE, OP_EVADE: flee_d = 1'b1;
      OP_IVEHPT: begin
        sx_d = SUMW'(ax) + SUMW'(hx) + SUMW'(bx);
        sy_d = SUMW'(ay) + SUMW'(hy) + SUMW'(by);
      end
      OP_IVEHICLES: begin
        sx_d = SUMW'(ax) + SUMW'(hx) + SUMW'(bx) + SUMW'(vx);
        sy_d = SUMW'(ay) + SUMW'(hy) + SUMW'(by) + SUMW'(vy);
      end
      default: kill_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op   <= operation;
      s1_kill <= kill_d;
      s1_flee <= flee_d;
      s1_px   <= 64'(hx) * 64'(aspd_s);
      s1_py   <= 64'(hy) * 64'(aspd_s);
      s1_sx   <= sx_d;
      s1_sy   <= sy_d;
      s1_ax   <= ax;
      s1_ay   <= ay;
      s1_ox   <= signed'(own_pos[63:32]);
      s1_oy   <= signed'(own_pos[31:0]);
      s1_spd  <= own_max_speed;
    end
  end

  // Stage 2: target point and direction
  logic signed [TW-1:0] tx, ty;
  logic signed [63:0]   shx, shy;
  logic signed [SUMW-1:0] mdx, mdy;
  assign shx = s1_px >>> FRAC_BITS;
  assign shy = s1_py >>> FRAC_BITS;
  assign mdx = s1_sx >>> 1;
  assign mdy = s1_sy >>> 1;

  always_comb begin
    case (op_t'(s1_op))
      OP_PURSUIT, OP_EVADE: begin
        tx = TW'(s1_ax) + TW'(shx);
        ty = TW'(s1_ay) + TW'(shy);
      end
      OP_IVEHPT, OP_IVEHICLES, OP_IPOINTS: begin
        tx = TW'(mdx);
        ty = TW'(mdy);
      end
      default: begin
        tx = TW'(s1_ax);
        ty = TW'(s1_ay);
      end
    endcase
  end

  logic                 s2_v, s2_kill, s2_flee;
  logic signed [DW-1:0] s2_dx, s2_dy;
  logic [SpeedW-1:0]    s2_spd;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kill <= s1_kill;
      s2_flee <= s1_flee;
      s2_spd  <= s1_spd;
      if (s1_flee) begin
        s2_dx <= DW'(s1_ox) - DW'(tx);
        s2_dy <= DW'(s1_oy) - DW'(ty);
      end else begin
        s2_dx <= DW'(tx) - DW'(s1_ox);
        s2_dy <= DW'(ty) - DW'(s1_oy);
      end
    end
  end

  // Stage 3: magnitudes and partial products of the squares
  logic [MW-1:0] mx_d, my_d;
  assign mx_d = s2_dx[DW-1] ? MW'(-s2_dx) : MW'(s2_dx);
  assign my_d = s2_dy[DW-1] ? MW'(-s2_dy) : MW'(s2_dy);

  logic               s3_v, s3_kill, s3_flee, s3_sgx, s3_sgy;
  logic [MW-1:0]      s3_mx, s3_my;
  logic [SpeedW-1:0]  s3_spd;
  logic [2*HI-1:0]    s3_hhx, s3_hhy;
  logic [HI+LO-1:0]   s3_hlx, s3_hly;
  logic [2*LO-1:0]    s3_llx, s3_lly;
  logic [SPW-1:0]     s3_spd2, s3_fr2;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kill <= s2_kill;
      s3_flee <= s2_flee;
      s3_sgx  <= s2_dx[DW-1];
      s3_sgy  <= s2_dy[DW-1];
      s3_mx   <= mx_d;
      s3_my   <= my_d;
      s3_spd  <= s2_spd;
      s3_hhx  <= (2*HI)'(mx_d[MW-1:LO]) * (2*HI)'(mx_d[MW-1:LO]);
      s3_hhy  <= (2*HI)'(my_d[MW-1:LO]) * (2*HI)'(my_d[MW-1:LO]);
      s3_hlx  <= (HI+LO)'(mx_d[MW-1:LO]) * (HI+LO)'(mx_d[LO-1:0]);
      s3_hly  <= (HI+LO)'(my_d[MW-1:LO]) * (HI+LO)'(my_d[LO-1:0]);
      s3_llx  <= (2*LO)'(mx_d[LO-1:0]) * (2*LO)'(mx_d[LO-1:0]);
      s3_lly  <= (2*LO)'(my_d[LO-1:0]) * (2*LO)'(my_d[LO-1:0]);
      s3_spd2 <= SPW'(s2_spd) * SPW'(s2_spd);
      s3_fr2  <= SPW'(flee_radius) * SPW'(flee_radius);
    end
  end

  // Stage 4: per-axis squares
  logic               s4_v, s4_kill, s4_flee, s4_sgx, s4_sgy;
  logic [MW-1:0]      s4_mx, s4_my;
  logic [SpeedW-1:0]  s4_spd;
  logic [SW-1:0]      s4_sqx, s4_sqy;
  logic [SPW-1:0]     s4_spd2, s4_fr2;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_kill <= s3_kill;
      s4_flee <= s3_flee;
      s4_sgx  <= s3_sgx;
      s4_sgy  <= s3_sgy;
      s4_mx   <= s3_mx;
      s4_my   <= s3_my;
      s4_spd  <= s3_spd;
      s4_spd2 <= s3_spd2;
      s4_fr2  <= s3_fr2;
      s4_sqx  <= (SW'(s3_hhx) << (2*LO)) + (SW'(s3_hlx) << (LO+1)) + SW'(s3_llx);
      s4_sqy  <= (SW'(s3_hhy) << (2*LO)) + (SW'(s3_hly) << (LO+1)) + SW'(s3_lly);
    end
  end

  // Stage 5: squared length and the distance cut-offs
  logic [SQW-1:0] m2;
  logic           cut;
  assign m2  = SQW'(s4_sqx) + SQW'(s4_sqy);
  assign cut = (m2 == '0) ||
               (s4_flee ? (m2 > SQW'(s4_fr2)) : (m2 < SQW'(s4_spd2)));

  logic           sq_v    [0:RW];
  car_t           sq_c    [0:RW];
  logic [SQW-1:0] sq_rem  [0:RW];
  logic [RW-1:0]  sq_root [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= s4_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_c[0]    <= '{kill: s4_kill || cut, sgx: s4_sgx, sgy: s4_sgy,
                      mx: s4_mx, my: s4_my, spd: s4_spd};
      sq_rem[0]  <= m2;
      sq_root[0] <= '0;
    end
  end

  // Square root: one root bit per stage, most significant first.
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int I = RW - 1 - k;
    logic [TW2-1:0] trial;
    logic           ge;
    assign trial = (TW2'(sq_root[k]) << (I + 1)) | (TW2'(1) << (2 * I));
    assign ge    = TW2'(sq_rem[k]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c[k+1]    <= sq_c[k];
        sq_rem[k+1]  <= ge ? SQW'(TW2'(sq_rem[k]) - trial) : sq_rem[k];
        sq_root[k+1] <= ge ? (sq_root[k] | (RW'(1) << I)) : sq_root[k];
      end
    end
  end

  // Numerators: |d| times speed in two partial products, then summed.
  logic               m1_v;
  car_t               m1_c;
  logic [RW-1:0]      m1_len;
  logic [LO+SpeedW-1:0] m1_plx, m1_ply;
  logic [HI+SpeedW-1:0] m1_phx, m1_phy;
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (adv) begin
      m1_v <= sq_v[RW];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_c   <= sq_c[RW];
      m1_len <= sq_root[RW];
      m1_plx <= (LO+SpeedW)'(sq_c[RW].mx[LO-1:0]) * (LO+SpeedW)'(sq_c[RW].spd);
      m1_ply <= (LO+SpeedW)'(sq_c[RW].my[LO-1:0]) * (LO+SpeedW)'(sq_c[RW].spd);
      m1_phx <= (HI+SpeedW)'(sq_c[RW].mx[MW-1:LO]) * (HI+SpeedW)'(sq_c[RW].spd);
      m1_phy <= (HI+SpeedW)'(sq_c[RW].my[MW-1:LO]) * (HI+SpeedW)'(sq_c[RW].spd);
    end
  end

  logic             dv_v    [0:QuotW];
  logic             dv_kill [0:QuotW];
  logic             dv_sgx  [0:QuotW];
  logic             dv_sgy  [0:QuotW];
  logic [RW-1:0]    dv_len  [0:QuotW];
  logic [CW-1:0]    dv_rx   [0:QuotW];
  logic [CW-1:0]    dv_ry   [0:QuotW];
  logic [QuotW-1:0] dv_qx   [0:QuotW];
  logic [QuotW-1:0] dv_qy   [0:QuotW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= m1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_kill[0] <= m1_c.kill;
      dv_sgx[0]  <= m1_c.sgx;
      dv_sgy[0]  <= m1_c.sgy;
      dv_len[0]  <= m1_len;
      dv_rx[0]   <= CW'((NW'(m1_phx) << LO) + NW'(m1_plx));
      dv_ry[0]   <= CW'((NW'(m1_phy) << LO) + NW'(m1_ply));
      dv_qx[0]   <= '0;
      dv_qy[0]   <= '0;
    end
  end

  // Restoring division: one quotient bit per stage for each axis.
  for (genvar k = 0; k < QuotW; k++) begin : g_div
    localparam int J = QuotW - 1 - k;
    logic [CW-1:0] dshift;
    logic          gex, gey;
    assign dshift = CW'(dv_len[k]) << J;
    assign gex    = dv_rx[k] >= dshift;
    assign gey    = dv_ry[k] >= dshift;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_kill[k+1] <= dv_kill[k];
        dv_sgx[k+1]  <= dv_sgx[k];
        dv_sgy[k+1]  <= dv_sgy[k];
        dv_len[k+1]  <= dv_len[k];
        dv_rx[k+1]   <= gex ? dv_rx[k] - dshift : dv_rx[k];
        dv_ry[k+1]   <= gey ? dv_ry[k] - dshift : dv_ry[k];
        dv_qx[k+1]   <= gex ? (dv_qx[k] | (QuotW'(1) << J)) : dv_qx[k];
        dv_qy[k+1]   <= gey ? (dv_qy[k] | (QuotW'(1) << J)) : dv_qy[k];
      end
    end
  end

  // Output word: clip, restore the sign, and force zero for dropped requests.
  localparam logic [QuotW-1:0] QMax = QuotW'(32'h7FFF_FFFF);
  logic [QuotW-1:0] cqx, cqy;
  assign cqx = (dv_qx[QuotW] > QMax) ? QMax : dv_qx[QuotW];
  assign cqy = (dv_qy[QuotW] > QMax) ? QMax : dv_qy[QuotW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[QuotW];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (dv_kill[QuotW]) begin
        force_x <= '0;
        force_y <= '0;
      end else begin
        force_x <= dv_sgx[QuotW] ? -signed'(cqx) : signed'(cqx);
        force_y <= dv_sgy[QuotW] ? -signed'(cqy) : signed'(cqy);
      end
    end
  end

  // The finished root leaves a remainder of at most twice the root.
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sq_v[RW] |-> (TW2'(sq_rem[RW]) <= (TW2'(sq_root[RW]) << 1)))
    else $error("square root remainder out of range");

  // A live numerator must give a quotient that fits the divider.
  a_div_fit: assert property (@(posedge clk) disable iff (rst)
    (dv_v[0] && !dv_kill[0]) |->
      ((dv_rx[0] < (CW'(dv_len[0]) << QuotW)) && (dv_ry[0] < (CW'(dv_len[0]) << QuotW))))
    else $error("divider numerator too large for quotient width");

  // A live division ends with remainders below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_v[QuotW] && !dv_kill[QuotW]) |->
      ((dv_rx[QuotW] < CW'(dv_len[QuotW])) && (dv_ry[QuotW] < CW'(dv_len[QuotW]))))
    else $error("divider remainder not below divisor");

  // A held output word keeps the last pipeline stage frozen.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(dv_v[QuotW]) && $stable(dv_qx[QuotW])))
    else $error("pipeline advanced under a stalled output word");

endmodule
`default_nettype wire
